// ===== sv/assert_macros.svh =====
// Assertion macros shared by the UDP/IPv4 fragment header generator modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== sv/uifg_pkg.sv =====
// Package for the UDP/IPv4 fragment header generator: constants, register
// indexes, controller states, command/status structs and the checksum fold.
// No dependencies.
package uifg_pkg;

	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_MTU      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_ADDR = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CSUM_EN  = 8'd2;

	localparam logic [13:0] MTU_RESET     = 14'd1500;
	localparam logic [13:0] MTU_MIN       = 14'd576;
	localparam logic [13:0] MTU_MAX       = 14'd9000;
	localparam logic [13:0] IP_HDR_BYTES  = 14'd20;
	localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
	localparam logic [15:0] PROTO_UDP     = 16'd17;
	localparam logic [15:0] IP_VER_IHL    = 16'h4500;
	localparam logic [15:0] TTL_PROTO     = 16'hFF11;
	localparam logic [15:0] CKSUM_ONES    = 16'hFFFF;
	localparam logic [15:0] MAX_PAYLOAD_BYTES = 16'd32767;
	localparam logic [5:0]  MAX_FRAGS     = 6'd60;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SUM1,
		S_SUM2,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic sum1;
		logic sum2;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic oversize;
		logic out_free;
		logic final_frag;
	} sts_t;

	// Ones'-complement fold of a 20-bit sum down to 16 bits.
	function automatic logic [15:0] fold16(input logic [19:0] s);
		logic [16:0] t;
		logic [16:0] u;
		t = {1'b0, s[15:0]} + {13'd0, s[19:16]};
		u = {1'b0, t[15:0]} + {16'd0, t[16]};
		return u[15:0];
	endfunction

endpackage

// ===== sv/uifg_ctrl.sv =====
// Controller for the fragment header generator: sequences accept, two
// checksum steps and one fragment per free output slot. Uses uifg_pkg.
module uifg_ctrl import uifg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);
`include "assert_macros.svh"

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					// drop oversize datagrams without leaving idle
					if (!sts.oversize) begin
						state_d = S_SUM1;
					end
				end
			end
			S_SUM1: begin
				cmd.sum1 = 1'b1;
				state_d  = S_SUM2;
			end
			S_SUM2: begin
				cmd.sum2 = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.final_frag) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`ASSERT_SAME(a_emit_needs_slot, cmd.emit, sts.out_free)
	`ASSERT_NEXT(a_sum2_to_emit, state_q == S_SUM2, state_q == S_EMIT)
	`ASSERT_NEXT(a_load_starts, cmd.load && !sts.oversize, state_q == S_SUM1 && !in_ready)

endmodule

// ===== sv/uifg_datapath.sv =====
// Datapath for the fragment header generator: configuration registers, UDP
// checksum, fragment counters and the output register. Uses uifg_pkg.
module uifg_datapath import uifg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic [14:0]          payload_len,
	input  logic [15:0]          payload_sum,
	input  logic [31:0]          dst_addr,
	input  logic [15:0]          dst_port,
	input  logic [15:0]          src_port,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [15:0]          ident,
	output logic [12:0]          frag_offset,
	output logic [13:0]          total_length,
	output logic [15:0]          header_checksum,
	output logic [15:0]          udp_length,
	output logic [15:0]          udp_checksum,
	output logic                 last
);
`include "assert_macros.svh"

	// configuration
	logic [13:0] mtu_q;
	logic [31:0] src_addr_q;
	logic        csum_en_q;

	// per-datagram state
	logic [15:0] next_ident_q;
	logic [15:0] cur_ident_q;
	logic [15:0] ulen_q;
	logic [15:0] psum_q;
	logic [31:0] dst_q;
	logic [15:0] dport_q;
	logic [15:0] sport_q;
	logic [17:0] addr_sum_q;
	logic [19:0] port_sum_q;
	logic [19:0] base_hdr_q;
	logic [15:0] ucks_q;
	logic [13:0] maxlen_q;
	logic [15:0] bytes_left_q;
	logic [15:0] byte_offset_q;
	logic [5:0]  frag_cnt_q;

	// output register
	logic        out_valid_q;
	logic [15:0] out_ident_q;
	logic [12:0] out_offset_q;
	logic [13:0] out_total_q;
	logic [15:0] out_hcks_q;
	logic [15:0] out_ulen_q;
	logic [15:0] out_ucks_q;
	logic        out_last_q;

	logic        oversize;
	logic [19:0] udp_sum;
	logic [15:0] udp_cks;
	logic [13:0] eff_mtu;
	logic [13:0] maxlen;
	logic        frag_fits;
	logic [15:0] frag_len;
	logic [13:0] frag_tot;
	logic [15:0] flag_field;
	logic [19:0] hdr_sum;
	logic        out_free;

	assign oversize = {1'b0, payload_len} > MAX_PAYLOAD_BYTES;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mtu_q      <= MTU_RESET;
			src_addr_q <= '0;
			csum_en_q  <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MTU:      mtu_q      <= cfg_data[13:0];
				CFG_SRC_ADDR: src_addr_q <= cfg_data;
				CFG_CSUM_EN:  csum_en_q  <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	// second checksum step and fragment size limit
	always_comb begin
		udp_sum = 20'(addr_sum_q) + port_sum_q;
		udp_cks = ~fold16(udp_sum);
		if (udp_cks == 16'd0) begin
			udp_cks = CKSUM_ONES;
		end
		if (!csum_en_q) begin
			udp_cks = 16'd0;
		end
		if (mtu_q < MTU_MIN) begin
			eff_mtu = MTU_MIN;
		end else if (mtu_q > MTU_MAX) begin
			eff_mtu = MTU_MAX;
		end else begin
			eff_mtu = mtu_q;
		end
		maxlen = (eff_mtu - IP_HDR_BYTES) & ~14'd7;
	end

	// current fragment
	always_comb begin
		frag_fits  = bytes_left_q <= {2'b00, maxlen_q};
		frag_len   = frag_fits ? bytes_left_q : {2'b00, maxlen_q};
		frag_tot   = IP_HDR_BYTES + frag_len[13:0];
		flag_field = {2'b00, !frag_fits, byte_offset_q[15:3]};
		hdr_sum    = base_hdr_q + 20'(frag_tot) + 20'(flag_field);
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_ident_q <= '0;
			bytes_left_q <= '0;
			byte_offset_q <= '0;
			frag_cnt_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load && !oversize) begin
				next_ident_q <= next_ident_q + 16'd1;
			end
			if (cmd.sum2) begin
				bytes_left_q  <= ulen_q;
				byte_offset_q <= '0;
				frag_cnt_q    <= '0;
			end
			if (cmd.emit) begin
				bytes_left_q  <= bytes_left_q - frag_len;
				byte_offset_q <= byte_offset_q + frag_len;
				frag_cnt_q    <= frag_cnt_q + 6'd1;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_ident_q <= next_ident_q;
			ulen_q      <= 16'(payload_len) + UDP_HDR_BYTES;
			psum_q      <= payload_sum;
			dst_q       <= dst_addr;
			dport_q     <= dst_port;
			sport_q     <= src_port;
		end
		if (cmd.sum1) begin
			addr_sum_q <= 18'(src_addr_q[31:16]) + 18'(src_addr_q[15:0])
				+ 18'(dst_q[31:16]) + 18'(dst_q[15:0]);
			port_sum_q <= 20'(PROTO_UDP) + 20'(sport_q) + 20'(dport_q)
				+ 20'(psum_q) + {3'd0, ulen_q, 1'b0};
		end
		if (cmd.sum2) begin
			ucks_q     <= udp_cks;
			maxlen_q   <= maxlen;
			base_hdr_q <= 20'(IP_VER_IHL) + 20'(TTL_PROTO) + 20'(cur_ident_q)
				+ 20'(addr_sum_q);
		end
		if (cmd.emit) begin
			out_ident_q  <= cur_ident_q;
			out_offset_q <= byte_offset_q[15:3];
			out_total_q  <= frag_tot;
			out_hcks_q   <= ~fold16(hdr_sum);
			out_ulen_q   <= ulen_q;
			out_ucks_q   <= ucks_q;
			out_last_q   <= frag_fits;
		end
	end

	always_comb begin
		sts.oversize   = oversize;
		sts.out_free   = out_free;
		sts.final_frag = frag_fits || (frag_cnt_q == MAX_FRAGS - 6'd1);
	end

	assign out_valid       = out_valid_q;
	assign ident           = out_ident_q;
	assign frag_offset     = out_offset_q;
	assign total_length    = out_total_q;
	assign header_checksum = out_hcks_q;
	assign udp_length      = out_ulen_q;
	assign udp_checksum    = out_ucks_q;
	assign last            = out_last_q;

	`ASSERT_SAME(a_mid_frag_full, out_valid_q && !out_last_q, out_total_q == IP_HDR_BYTES + maxlen_q)
	`ASSERT_NEXT(a_ident_step, cmd.load && !oversize, next_ident_q == $past(next_ident_q) + 16'd1)

endmodule

// ===== sv/udp_ipv4_fragment_header_gen.sv =====
// UDP checksum and IPv4 fragment header generator, top level.
// After the datagram transaction the controller steps through SUM1 and SUM2, then its
// emit loop registers the N fragment headers (N <= 60) one header per cycle, less output
// back-pressure; the next datagram is taken only once the controller is back in idle.
// Reset: async active low; mtu 1500, src_addr 0, checksum on, ident 0.
// Oversize datagrams are taken while idle and produce nothing.
module udp_ipv4_fragment_header_gen import uifg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [14:0]          payload_len,
	input  logic [15:0]          payload_sum,
	input  logic [31:0]          dst_addr,
	input  logic [15:0]          dst_port,
	input  logic [15:0]          src_port,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          ident,
	output logic [12:0]          frag_offset,
	output logic [13:0]          total_length,
	output logic [15:0]          header_checksum,
	output logic [15:0]          udp_length,
	output logic [15:0]          udp_checksum,
	output logic                 last
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	uifg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	uifg_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.payload_len     (payload_len),
		.payload_sum     (payload_sum),
		.dst_addr        (dst_addr),
		.dst_port        (dst_port),
		.src_port        (src_port),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.ident           (ident),
		.frag_offset     (frag_offset),
		.total_length    (total_length),
		.header_checksum (header_checksum),
		.udp_length      (udp_length),
		.udp_checksum    (udp_checksum),
		.last            (last)
	);

endmodule

// ===== tb/udp_ipv4_fragment_header_gen_tb.sv =====
// Testbench for udp_ipv4_fragment_header_gen: drives datagram descriptors and register
// writes, predicts every IPv4 fragment header and checks each one in order.
// Depends on uifg_pkg and the udp_ipv4_fragment_header_gen RTL only.
`timescale 1ns / 100ps

module udp_ipv4_fragment_header_gen_tb;
	import uifg_pkg::*;

	localparam int RESET_CYCLES   = 12;
	localparam int IDLE_PCT       = 16;
	localparam int STALL_CYCLES   = 400;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFF;

	typedef struct packed {
		logic [15:0] ident;
		logic [12:0] frag_offset;
		logic [13:0] total_length;
		logic [15:0] header_checksum;
		logic [15:0] udp_length;
		logic [15:0] udp_checksum;
		logic        last;
	} frag_hdr_t;

	// Predicts the fragment headers of each datagram and holds them until they come out.
	class frag_header_model;
		logic [13:0] mtu;
		logic [31:0] src_addr;
		logic        csum_en;
		logic [15:0] next_ident;
		frag_hdr_t   expected_headers[$];
		int          errors;

		function new();
			mtu = MTU_RESET;
			src_addr = '0;
			csum_en = 1'b1;
			next_ident = '0;
			errors = 0;
		endfunction

		function logic [15:0] ones_fold(logic [31:0] s);
			s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
			s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
			return s[15:0];
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				CFG_MTU: begin
					mtu = data[13:0];
				end
				CFG_SRC_ADDR: begin
					src_addr = data;
				end
				CFG_CSUM_EN: begin
					csum_en = data[0];
				end
				default: begin
				end
			endcase
		endfunction

		function void note_datagram(logic [14:0] plen, logic [15:0] psum, logic [31:0] dst,
				logic [15:0] dport, logic [15:0] sport);
			logic [15:0] ulen;
			logic [15:0] ucks;
			logic [15:0] id;
			logic [13:0] eff_mtu;
			logic [15:0] max_data;
			logic [15:0] left;
			logic [15:0] offset;
			logic [15:0] len;
			logic [13:0] tot;
			logic [31:0] s;
			logic        lst;
			frag_hdr_t   hdr;
			int          n;

			if ({1'b0, plen} > MAX_PAYLOAD_BYTES)
				return;
			ulen = {1'b0, plen} + UDP_HDR_BYTES;
			ucks = '0;
			if (csum_en) begin
				s = 32'(src_addr[31:16]) + 32'(src_addr[15:0]) + 32'(dst[31:16])
					+ 32'(dst[15:0]) + 32'(PROTO_UDP) + 32'(ulen) + 32'(sport)
					+ 32'(dport) + 32'(ulen) + 32'(psum);
				ucks = ~ones_fold(s);
				if (ucks == '0)
					ucks = CKSUM_ONES;
			end
			id = next_ident;
			next_ident = next_ident + 16'd1;

			eff_mtu = mtu;
			if (eff_mtu < MTU_MIN)
				eff_mtu = MTU_MIN;
			if (eff_mtu > MTU_MAX)
				eff_mtu = MTU_MAX;
			max_data = {2'b00, (eff_mtu - IP_HDR_BYTES) & ~14'd7};

			left = ulen;
			offset = '0;
			n = 0;
			do begin
				len = left;
				lst = 1'b1;
				if (len > max_data) begin
					len = max_data;
					lst = 1'b0;
				end
				tot = IP_HDR_BYTES + len[13:0];
				s = 32'(IP_VER_IHL) + 32'(tot) + 32'(id) + 32'({2'b00, ~lst, offset[15:3]})
					+ 32'(TTL_PROTO) + 32'(src_addr[31:16]) + 32'(src_addr[15:0])
					+ 32'(dst[31:16]) + 32'(dst[15:0]);
				hdr.ident = id;
				hdr.frag_offset = offset[15:3];
				hdr.total_length = tot;
				hdr.header_checksum = ~ones_fold(s);
				hdr.udp_length = ulen;
				hdr.udp_checksum = ucks;
				hdr.last = lst;
				expected_headers.push_back(hdr);
				left = left - len;
				offset = offset + len;
				n++;
			end while (!lst && n < int'(MAX_FRAGS));
		endfunction

		function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %h actual %h", $time, name, want, got);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void check_header(frag_hdr_t got);
			frag_hdr_t want;
			bit        ok;

			if (expected_headers.size() == 0) begin
				$display("%0t: header with no datagram pending, ident %h offset %h",
					$time, got.ident, got.frag_offset);
				errors++;
				return;
			end
			want = expected_headers.pop_front();
			ok = 1'b1;
			ok &= field_ok("ident", 32'(want.ident), 32'(got.ident));
			ok &= field_ok("frag_offset", 32'(want.frag_offset), 32'(got.frag_offset));
			ok &= field_ok("total_length", 32'(want.total_length), 32'(got.total_length));
			ok &= field_ok("header_checksum", 32'(want.header_checksum),
				32'(got.header_checksum));
			ok &= field_ok("udp_length", 32'(want.udp_length), 32'(got.udp_length));
			ok &= field_ok("udp_checksum", 32'(want.udp_checksum), 32'(got.udp_checksum));
			ok &= field_ok("last", 32'(want.last), 32'(got.last));
			if (!ok)
				errors++;
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [14:0]          payload_len = '0;
	logic [15:0]          payload_sum = '0;
	logic [31:0]          dst_addr = '0;
	logic [15:0]          dst_port = '0;
	logic [15:0]          src_port = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [15:0]          ident;
	logic [12:0]          frag_offset;
	logic [13:0]          total_length;
	logic [15:0]          header_checksum;
	logic [15:0]          udp_length;
	logic [15:0]          udp_checksum;
	logic                 last;

	frag_header_model hdr_model;
	bit calm = 1'b0;
	bit stall_req = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;

	udp_ipv4_fragment_header_gen i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.payload_len     (payload_len),
		.payload_sum     (payload_sum),
		.dst_addr        (dst_addr),
		.dst_port        (dst_port),
		.src_port        (src_port),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.ident           (ident),
		.frag_offset     (frag_offset),
		.total_length    (total_length),
		.header_checksum (header_checksum),
		.udp_length      (udp_length),
		.udp_checksum    (udp_checksum),
		.last            (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Header sink: check each transaction, then pick the next ready level.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				hdr_model.check_header({ident, frag_offset, total_length, header_checksum,
					udp_length, udp_checksum, last});
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (stall_req) begin
				out_ready <= 1'b0;
				stall_left <= STALL_CYCLES;
				stall_req <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Valid stays high unless a gap is drawn; back-to-back items need no second NBA.
	task automatic send_dgram(input logic [14:0] plen, input logic [15:0] psum,
			input logic [31:0] dst, input logic [15:0] dport, input logic [15:0] sport);
		in_valid <= 1'b1;
		payload_len <= plen;
		payload_sum <= psum;
		dst_addr <= dst;
		dst_port <= dport;
		src_port <= sport;
		do @(posedge clk); while (!in_ready);
		hdr_model.note_datagram(plen, psum, dst, dport, sport);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_random_dgram(input int max_len);
		int          pick;
		logic [14:0] plen;

		pick = $urandom_range(99);
		if (pick < 10)
			plen = 15'($urandom_range(0, max_len));
		else if (pick < 30 && max_len > 9000)
			plen = 15'($urandom_range(1473, 9000));
		else
			plen = 15'($urandom_range(0, 1500));
		send_dgram(plen, 16'($urandom_range(0, 65535)), $urandom(),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
	endtask

	// Drain all headers, let the block settle, then write one register.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		in_valid <= 1'b0;
		while (hdr_model.expected_headers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		hdr_model.write_reg(idx, data);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] s_zero;
		logic [15:0] psum_zero;

		hdr_model = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero payload, all-ones fields, exact and one-over fragment fit.
		send_dgram(15'd0, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000);
		send_dgram(15'h7FFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		send_dgram(15'd1472, 16'h1234, 32'hC0A8_0001, 16'd53, 16'd1024);
		send_dgram(15'd1473, 16'hA5A5, 32'h0A00_00FE, 16'd8080, 16'd5353);

		// Pick the payload sum that makes the checksum fold to zero.
		s_zero = 32'(hdr_model.src_addr[31:16]) + 32'(hdr_model.src_addr[15:0])
			+ 32'h0A00 + 32'h0001 + 32'(PROTO_UDP)
			+ 32'd2 * (32'd100 + 32'(UDP_HDR_BYTES)) + 32'd4000 + 32'd5000;
		psum_zero = ~hdr_model.ones_fold(s_zero);
		send_dgram(15'd100, psum_zero, 32'h0A00_0001, 16'd5000, 16'd4000);

		write_reg(CFG_CSUM_EN, 32'h0);
		send_dgram(15'd200, 16'h4321, 32'h7F00_0001, 16'd7, 16'd9);
		send_dgram(15'd0, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		write_reg(CFG_CSUM_EN, 32'hFFFF_FFFF);
		write_reg(CFG_SRC_ADDR, 32'hFFFF_FFFF);
		send_dgram(15'd3000, 16'h0001, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000);

		// MTU below, at and above its limits.
		write_reg(CFG_MTU, 32'd0);
		send_dgram(15'd2000, 16'h5555, 32'h0102_0304, 16'd1, 16'd2);
		write_reg(CFG_MTU, 32'd575);
		send_dgram(15'd1200, 16'hAAAA, 32'h0506_0708, 16'd3, 16'd4);
		write_reg(CFG_MTU, 32'd576);
		send_dgram(15'd544, 16'h0F0F, 32'h8000_0000, 16'd80, 16'd443);
		send_dgram(15'd545, 16'hF0F0, 32'h0000_0001, 16'd443, 16'd80);
		write_reg(CFG_MTU, 32'd9000);
		send_dgram(15'd8972, 16'h1111, 32'hDEAD_BEEF, 16'd123, 16'd456);
		send_dgram(15'd8973, 16'h2222, 32'hCAFE_F00D, 16'd789, 16'd321);
		write_reg(CFG_MTU, 32'd9001);
		send_dgram(15'd9000, 16'h3333, 32'h1234_5678, 16'd67, 16'd68);
		write_reg(CFG_MTU, 32'd16383);
		send_dgram(15'h7FFF, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000);

		// Writes to unused indexes leave every register alone.
		write_reg(CFG_UNUSED_LO, 32'h0);
		write_reg(CFG_UNUSED_HI, 32'hFFFF_FFFF);
		send_dgram(15'd3000, 16'h9999, 32'hAC10_0001, 16'd161, 16'd162);
		write_reg(CFG_MTU, 32'hFFFF_C000 | 32'd1500);
		write_reg(CFG_SRC_ADDR, $urandom());

		repeat (40) send_random_dgram(32767);

		write_reg(CFG_MTU, 32'd576);
		calm = 1'b1;
		repeat (30) send_random_dgram(32767);

		// Hold the sink off while items keep coming so the block backs up.
		write_reg(CFG_MTU, 32'd1500);
		stall_req <= 1'b1;
		repeat (12) send_random_dgram(1500);
		calm = 1'b0;

		write_reg(CFG_MTU, 32'd9000);
		write_reg(CFG_SRC_ADDR, $urandom());
		write_reg(CFG_CSUM_EN, 32'h0);
		repeat (30) send_random_dgram(32767);

		write_reg(CFG_CSUM_EN, 32'h1);
		write_reg(CFG_MTU, $urandom_range(0, 16383));
		repeat (40) send_random_dgram(32767);

		in_valid <= 1'b0;
		while (hdr_model.expected_headers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (hdr_model.errors == 0 && hdr_model.expected_headers.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0t: %0d bad headers, %0d still pending", $time, hdr_model.errors,
				hdr_model.expected_headers.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/uifg_pkg.sv
sv/uifg_ctrl.sv
sv/uifg_datapath.sv
sv/udp_ipv4_fragment_header_gen.sv
tb/udp_ipv4_fragment_header_gen_tb.sv
